/* rtl/core/scq_pkg.sv */
// Package for the stick cardinal quantizer: payload structs, direction and
// register codes, controller state and the threshold scaling function.
// No dependencies; the sequencer, the top level and the checker import it.
package scq_pkg;

    // Stick axes are signed Q1.(AXIS_BITS-1).
    localparam int AXIS_BITS = 16;
    localparam int MAG_BITS = AXIS_BITS;
    localparam int SUM_BITS = AXIS_BITS + 1;

    // Register widths and reset values.
    localparam int THR_BITS = 15;
    localparam int RATIO_BITS = 16;
    localparam int TURN_SHIFT = 12;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam logic [THR_BITS-1:0] ENGAGE_RESET = 15'd16384;
    localparam logic [THR_BITS-1:0] RELEASE_RESET = 15'd11469;
    localparam logic [RATIO_BITS-1:0] TURN_RESET = 16'd4096;

    // 1/sqrt(2) in Q0.16 for the 45 degree rotation.
    localparam int ROT_BITS = 16;
    localparam logic [ROT_BITS-1:0] INV_SQRT2_Q16 = 16'd46341;

    // Thresholds are Q0.15 and are moved to the stick format by a shift.
    localparam int THR_UP = (AXIS_BITS >= 16) ? AXIS_BITS - 16 : 0;
    localparam int THR_DN = (AXIS_BITS < 16) ? 16 - AXIS_BITS : 0;

    typedef enum logic [2:0] {
        DIR_NONE = 3'd0,
        DIR_N    = 3'd1,
        DIR_S    = 3'd2,
        DIR_W    = 3'd3,
        DIR_E    = 3'd4
    } dir_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ENGAGE  = 2'd0,
        CFG_RELEASE = 2'd1,
        CFG_TURN    = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_LOAD  = 3'd1,
        ST_ROT   = 3'd2,
        ST_RND   = 3'd3,
        ST_START = 3'd4,
        ST_SQ    = 3'd5,
        ST_EMIT  = 3'd6
    } state_t;

    typedef struct packed {
        logic                        pad_present;
        logic signed [AXIS_BITS-1:0] stick_x;
        logic signed [AXIS_BITS-1:0] stick_y;
        logic                        isometric;
        logic                        up_held;
        logic                        up_pressed;
        logic                        down_held;
        logic                        down_pressed;
        logic                        left_held;
        logic                        left_pressed;
        logic                        right_held;
        logic                        right_pressed;
    } sample_t;

    typedef struct packed {
        logic north_held;
        logic north_pressed;
        logic south_held;
        logic south_pressed;
        logic west_held;
        logic west_pressed;
        logic east_held;
        logic east_pressed;
    } result_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic shortcut;
        logic iso;
        logic rot_busy;
        logic sq_busy;
        logic out_free;
    } stat_t;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic idle;
        logic load;
        logic start_rot;
        logic round_mags;
        logic start_sq;
        logic emit;
    } ctrl_t;

    // Scale a Q0.15 threshold to the stick magnitude format.
    function automatic logic [MAG_BITS-1:0] scale_thr(input logic [THR_BITS-1:0] t);
        logic [AXIS_BITS+THR_BITS-1:0] w;
        w = (AXIS_BITS + THR_BITS)'(t);
        w = (w << THR_UP) >> THR_DN;
        return w[MAG_BITS-1:0];
    endfunction

endpackage

/* rtl/core/scq_sermul.sv */
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
// Standalone; used by the quantizer top level for rotation, squares and ratio.
module scq_sermul #(
    parameter int WA = 16,
    parameter int WB = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WA-1:0]    a,
    input  logic [WB-1:0]    b,
    output logic             busy,
    output logic [WA+WB-1:0] product
);

    localparam int CW = (WB > 1) ? $clog2(WB) : 1;
    localparam logic [CW-1:0] LAST = CW'(WB - 1);

    logic [WA+WB-1:0] prod_reg;
    logic [WA+WB-1:0] prod_next;
    logic [WA-1:0]    mcand_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [WA:0]      partial;

    // One step: add the multiplicand to the upper half when the low bit is set,
    // then shift the whole product right by one.
    always_comb
    begin
        partial = {1'b0, prod_reg[WA+WB-1:WB]}
                + (prod_reg[0] ? {1'b0, mcand_reg} : {(WA+1){1'b0}});
        prod_next = {partial, prod_reg[WB-1:1]};
    end

    // Step counter and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Product and multiplicand registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg  <= {{WA{1'b0}}, b};
            mcand_reg <= a;
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign busy    = busy_reg;
    assign product = prod_reg;

endmodule

/* rtl/core/scq_ctrl.sv */
// Sequencer of the stick cardinal quantizer: steps one sample through load,
// then as needed rotation, rounding and squaring, and result transfer. Depends on scq_pkg.
module scq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           sample_valid,
    input  scq_pkg::stat_t stat,
    output scq_pkg::ctrl_t ctrl
);

    import scq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (stat.shortcut)
                begin
                    state_next = ST_EMIT;
                end
                else if (stat.iso)
                begin
                    state_next = ST_ROT;
                end
                else
                begin
                    state_next = ST_START;
                end
            end
            ST_ROT:
            begin
                if (!stat.rot_busy)
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                if (!stat.sq_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Strobes to the datapath.
    always_comb
    begin
        ctrl            = '0;
        ctrl.idle       = (state_reg == ST_IDLE);
        ctrl.load       = (state_reg == ST_LOAD);
        ctrl.start_rot  = (state_reg == ST_LOAD) && !stat.shortcut && stat.iso;
        ctrl.round_mags = (state_reg == ST_RND);
        ctrl.start_sq   = (state_reg == ST_START);
        ctrl.emit       = (state_reg == ST_EMIT) && stat.out_free;
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/stick_cardinal_quantizer.sv */
// An absent pad or an active D-pad goes from load straight to the result; plain
// axes go through the squares and turn product, isometric axes through the
// rotation first. One sample at a time: the next transfer is taken once the
// result is registered and the sequencer is back in idle. Bit-serial multipliers
// do the arithmetic: rotation, squares and turn product. Reset restores defaults.
module stick_cardinal_quantizer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  scq_pkg::sample_t                    sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output scq_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scq_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [scq_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import scq_pkg::*;

    localparam int PROD_ROT = SUM_BITS + ROT_BITS;
    localparam int PROD_SQ = 2 * MAG_BITS;
    localparam int PROD_TURN = MAG_BITS + RATIO_BITS;

    // Configuration registers.
    logic [THR_BITS-1:0]   eng_reg;
    logic [THR_BITS-1:0]   rel_reg;
    logic [RATIO_BITS-1:0] ratio_reg;

    // Block state and per-sample working registers.
    dir_t                  last_dir_reg;
    logic                  last_iso_reg;
    dir_t                  prev_reg;
    sample_t               item_reg;
    logic [MAG_BITS-1:0]   xmag_reg;
    logic [MAG_BITS-1:0]   ymag_reg;
    logic                  xneg_reg;
    logic                  yneg_reg;

    // Output register.
    logic                  result_valid_reg;
    result_t               result_reg;
    result_t               result_next;
    dir_t                  dir_next;

    ctrl_t                 ctrl;
    stat_t                 stat;

    // Load-stage signals.
    logic [MAG_BITS-1:0]   xu;
    logic [MAG_BITS-1:0]   yu;
    logic [MAG_BITS-1:0]   x_abs;
    logic [MAG_BITS-1:0]   y_abs;
    logic [SUM_BITS-1:0]   s1;
    logic [SUM_BITS-1:0]   s2;
    logic [SUM_BITS-1:0]   s1_abs;
    logic [SUM_BITS-1:0]   s2_abs;
    logic                  dpad;
    dir_t                  prev_load;

    // Multiplier results.
    logic                  rot_x_busy;
    logic                  rot_y_busy;
    logic                  sq_x_busy;
    logic                  sq_y_busy;
    logic                  sq_e_busy;
    logic                  turn_busy;
    logic [PROD_ROT-1:0]   rot_x_prod;
    logic [PROD_ROT-1:0]   rot_y_prod;
    logic [PROD_SQ-1:0]    sq_x_prod;
    logic [PROD_SQ-1:0]    sq_y_prod;
    logic [PROD_SQ-1:0]    sq_e_prod;
    logic [PROD_TURN-1:0]  turn_prod;
    logic [MAG_BITS:0]     rx_round;
    logic [MAG_BITS:0]     ry_round;
    logic [MAG_BITS-1:0]   eng_scaled;
    logic [MAG_BITS-1:0]   cur_mag;

    // Decision signals.
    logic [PROD_SQ:0]      radius_sq;
    logic                  engaged;
    logic [MAG_BITS-1:0]   rel_scaled;
    logic                  x_neg;
    logic                  x_pos;
    logic                  y_neg;
    logic                  y_pos;
    logic                  held;
    logic                  prev_horiz;
    dir_t                  horiz_pick;
    dir_t                  vert_pick;
    dir_t                  fresh;
    dir_t                  stick_dir;
    logic [MAG_BITS-1:0]   turn_mag;
    logic                  turn_ok;

    // Sequencer.
    scq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .stat         (stat),
        .ctrl         (ctrl)
    );

    assign sample_stall = !ctrl.idle;
    assign cfg_ready    = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_reg   <= ENGAGE_RESET;
            rel_reg   <= RELEASE_RESET;
            ratio_reg <= TURN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ENGAGE:  eng_reg   <= cfg_data[THR_BITS-1:0];
                CFG_RELEASE: rel_reg   <= cfg_data[THR_BITS-1:0];
                CFG_TURN:    ratio_reg <= cfg_data[RATIO_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // Sample capture on transfer.
    always_ff @(posedge clk)
    begin
        if (ctrl.idle && sample_valid)
        begin
            item_reg <= sample;
        end
    end

    // Axis magnitudes and the rotation sums of the captured sample.
    always_comb
    begin
        xu     = item_reg.stick_x;
        yu     = item_reg.stick_y;
        x_abs  = xu[MAG_BITS-1] ? (~xu + 1'b1) : xu;
        y_abs  = yu[MAG_BITS-1] ? (~yu + 1'b1) : yu;
        s1     = {xu[MAG_BITS-1], xu} + {yu[MAG_BITS-1], yu};
        s2     = {yu[MAG_BITS-1], yu} - {xu[MAG_BITS-1], xu};
        s1_abs = s1[SUM_BITS-1] ? (~s1 + 1'b1) : s1;
        s2_abs = s2[SUM_BITS-1] ? (~s2 + 1'b1) : s2;
        dpad   = |{item_reg.up_held, item_reg.up_pressed,
                   item_reg.down_held, item_reg.down_pressed,
                   item_reg.left_held, item_reg.left_pressed,
                   item_reg.right_held, item_reg.right_pressed};
        prev_load = (item_reg.isometric != last_iso_reg) ? DIR_NONE : last_dir_reg;
    end

    assign stat.shortcut = !item_reg.pad_present || dpad;
    assign stat.iso      = item_reg.isometric;
    assign stat.rot_busy = rot_x_busy || rot_y_busy;
    assign stat.sq_busy  = sq_x_busy || sq_y_busy || sq_e_busy || turn_busy;
    assign stat.out_free = !result_valid_reg || !result_stall;

    // Round half away from zero after the 1/sqrt(2) products.
    assign rx_round = rot_x_prod[PROD_ROT-1:ROT_BITS]
                    + {{MAG_BITS{1'b0}}, rot_x_prod[ROT_BITS-1]};
    assign ry_round = rot_y_prod[PROD_ROT-1:ROT_BITS]
                    + {{MAG_BITS{1'b0}}, rot_y_prod[ROT_BITS-1]};

    // Orientation, previous direction and working magnitudes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_iso_reg <= 1'b0;
            last_dir_reg <= DIR_NONE;
        end
        else
        begin
            if (ctrl.load)
            begin
                last_iso_reg <= item_reg.isometric;
            end
            if (ctrl.emit)
            begin
                last_dir_reg <= dir_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prev_reg <= prev_load;
            if (item_reg.isometric)
            begin
                xneg_reg <= s1[SUM_BITS-1];
                yneg_reg <= s2[SUM_BITS-1];
            end
            else
            begin
                xneg_reg <= xu[MAG_BITS-1];
                yneg_reg <= yu[MAG_BITS-1];
                xmag_reg <= x_abs;
                ymag_reg <= y_abs;
            end
        end
        else if (ctrl.round_mags)
        begin
            xmag_reg <= rx_round[MAG_BITS-1:0];
            ymag_reg <= ry_round[MAG_BITS-1:0];
        end
    end

    // Rotation multipliers.
    scq_sermul #(.WA(SUM_BITS), .WB(ROT_BITS)) u_rot_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctrl.start_rot),
        .a       (s1_abs),
        .b       (INV_SQRT2_Q16),
        .busy    (rot_x_busy),
        .product (rot_x_prod)
    );

    scq_sermul #(.WA(SUM_BITS), .WB(ROT_BITS)) u_rot_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctrl.start_rot),
        .a       (s2_abs),
        .b       (INV_SQRT2_Q16),
        .busy    (rot_y_busy),
        .product (rot_y_prod)
    );

    // Squares for the engage test and the product for the turn test.
    assign eng_scaled = scale_thr(eng_reg);
    assign prev_horiz = (prev_reg == DIR_W) || (prev_reg == DIR_E);
    assign cur_mag    = prev_horiz ? xmag_reg : ymag_reg;

    scq_sermul #(.WA(MAG_BITS), .WB(MAG_BITS)) u_sq_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctrl.start_sq),
        .a       (xmag_reg),
        .b       (xmag_reg),
        .busy    (sq_x_busy),
        .product (sq_x_prod)
    );

    scq_sermul #(.WA(MAG_BITS), .WB(MAG_BITS)) u_sq_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctrl.start_sq),
        .a       (ymag_reg),
        .b       (ymag_reg),
        .busy    (sq_y_busy),
        .product (sq_y_prod)
    );

    scq_sermul #(.WA(MAG_BITS), .WB(MAG_BITS)) u_sq_e (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctrl.start_sq),
        .a       (eng_scaled),
        .b       (eng_scaled),
        .busy    (sq_e_busy),
        .product (sq_e_prod)
    );

    scq_sermul #(.WA(MAG_BITS), .WB(RATIO_BITS)) u_turn (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctrl.start_sq),
        .a       (cur_mag),
        .b       (ratio_reg),
        .busy    (turn_busy),
        .product (turn_prod)
    );

    // Direction decision with engage, release and turn hysteresis.
    always_comb
    begin
        radius_sq  = {1'b0, sq_x_prod} + {1'b0, sq_y_prod};
        engaged    = radius_sq >= {1'b0, sq_e_prod};
        rel_scaled = scale_thr(rel_reg);
        x_neg      = xneg_reg && (xmag_reg != '0);
        x_pos      = !xneg_reg && (xmag_reg != '0);
        y_neg      = yneg_reg && (ymag_reg != '0);
        y_pos      = !yneg_reg && (ymag_reg != '0);

        case (prev_reg)
            DIR_N:   held = !y_pos && (ymag_reg >= rel_scaled);
            DIR_S:   held = !y_neg && (ymag_reg >= rel_scaled);
            DIR_W:   held = !x_pos && (xmag_reg >= rel_scaled);
            DIR_E:   held = !x_neg && (xmag_reg >= rel_scaled);
            default: held = 1'b0;
        endcase

        horiz_pick = x_neg ? DIR_W : DIR_E;
        vert_pick  = y_neg ? DIR_N : DIR_S;
        fresh      = (xmag_reg > ymag_reg) ? horiz_pick : vert_pick;
        turn_mag   = prev_horiz ? ymag_reg : xmag_reg;
        turn_ok    = engaged
                   && ({{(RATIO_BITS-TURN_SHIFT){1'b0}}, turn_mag, {TURN_SHIFT{1'b0}}}
                       >= turn_prod);

        if (!held)
        begin
            stick_dir = engaged ? fresh : DIR_NONE;
        end
        else if (turn_ok)
        begin
            stick_dir = prev_horiz ? vert_pick : horiz_pick;
        end
        else
        begin
            stick_dir = prev_reg;
        end
    end

    // Result fields: pad absent, D-pad pass-through or stick direction.
    always_comb
    begin
        result_next = '0;
        dir_next    = DIR_NONE;
        if (!item_reg.pad_present)
        begin
            result_next = '0;
        end
        else if (dpad)
        begin
            result_next.north_held    = item_reg.up_held | item_reg.up_pressed;
            result_next.north_pressed = item_reg.up_pressed;
            result_next.south_held    = item_reg.down_held | item_reg.down_pressed;
            result_next.south_pressed = item_reg.down_pressed;
            result_next.west_held     = item_reg.left_held | item_reg.left_pressed;
            result_next.west_pressed  = item_reg.left_pressed;
            result_next.east_held     = item_reg.right_held | item_reg.right_pressed;
            result_next.east_pressed  = item_reg.right_pressed;
        end
        else
        begin
            dir_next = stick_dir;
            case (stick_dir)
                DIR_N:
                begin
                    result_next.north_held    = 1'b1;
                    result_next.north_pressed = (stick_dir != prev_reg);
                end
                DIR_S:
                begin
                    result_next.south_held    = 1'b1;
                    result_next.south_pressed = (stick_dir != prev_reg);
                end
                DIR_W:
                begin
                    result_next.west_held    = 1'b1;
                    result_next.west_pressed = (stick_dir != prev_reg);
                end
                DIR_E:
                begin
                    result_next.east_held    = 1'b1;
                    result_next.east_pressed = (stick_dir != prev_reg);
                end
                default:
                begin
                    result_next = '0;
                end
            endcase
        end
    end

    // Output register: holds a result until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* rtl/core/scq_checker.sv */
// Port-level checker for the stick cardinal quantizer and its bind to the
// top level. Depends on scq_pkg and stick_cardinal_quantizer.
module scq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                sample_valid,
    input logic                                sample_stall,
    input scq_pkg::sample_t                    sample,
    input logic                                result_valid,
    input logic                                result_stall,
    input scq_pkg::result_t                    result,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [scq_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input logic [scq_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import scq_pkg::*;

    // A direction reported as pressed is also reported as held.
    a_press_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            ((!result.north_pressed || result.north_held)
             && (!result.south_pressed || result.south_held)
             && (!result.west_pressed || result.west_held)
             && (!result.east_pressed || result.east_held)))
        else $error("pressed direction without held");

    // A stalled result stays put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

    // One sample is worked on at a time.
    a_one_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> sample_stall)
        else $error("second sample taken while busy");

    // A new result appears only at the end of a sample's work.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_stall))
        else $error("result appeared without a sample in work");

endmodule

bind stick_cardinal_quantizer scq_checker u_scq_checker (.*);
